// ===== rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg: shared definitions for the chained hash map
// Field widths, operation and status codes, and the back-end state type.
// ----------------------------------------------------------------------------
package chm_pkg;

    // Default geometry of the store.
    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 4;

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 24;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    // Bucket remainder: key bits folded in per cycle and steps per key.
    localparam int REM_BITS  = 8;
    localparam int REM_STEPS = KEY_W / REM_BITS;
    localparam int STEP_W    = 2;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Operation codes as they arrive on the input channel.
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_FIND = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND       = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_ADDED       = 3'd2,
        ST_UPDATED     = 3'd3,
        ST_DELETED     = 3'd4,
        ST_DEL_MISSING = 3'd5,
        ST_FULL        = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_FETCH = 2'd1,
        BK_LOOK  = 2'd2,
        BK_EXEC  = 2'd3
    } back_state_t;

endpackage

// ===== rtl/chained_hash_map_top.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_top: key-value map with fixed-way bucket chaining
// Add, delete and find on 24-bit keys with 64-bit values, one result per word.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Word contents (lowest bit first)            | Accepted when
//  --------+-----+---------------------------------------------+---------------------
//  s_      | in  | tuser: kind; tdata: phone_key, entry_value  | s_tvalid && s_tready
//  m_      | out | tuser: status; tdata: found_value           | m_tvalid && m_tready
//
// The front stage takes a new word only once the last one has gone to the
// queue; the bucket index is the key modulo BUCKETS, formed as a restoring
// remainder eight key bits a cycle. The back stage takes each word through a
// bucket read, a way compare and a write-back with the result, and fetches no
// new word from the queue until the last one's result is registered.
// After reset the back stage clears the key store, one bucket a cycle, over
// all BUCKETS buckets; words are still taken into the front stage and the queue
// meanwhile, but no result comes out until the clearing pass has ended.
// A stalled result holds the back stage; once the two-entry queue and the
// front stage are full, s_tready falls until the result is taken.
//
module chained_hash_map_top #(
    parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
    parameter int WAYS    = chm_pkg::DEF_WAYS
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Input words.
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [chm_pkg::KIND_W-1:0]                s_tuser,  // kind
    input  logic [chm_pkg::KEY_W+chm_pkg::VAL_W-1:0]  s_tdata,  // phone_key, entry_value
    // Result words.
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [chm_pkg::STATUS_W-1:0]              m_tuser,  // status
    output logic [chm_pkg::VAL_W-1:0]                 m_tdata   // found_value
);

    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int QW = chm_pkg::OP_W + chm_pkg::KEY_W + IW + chm_pkg::VAL_W;

    logic          fq_valid, fq_ready, qb_valid, qb_ready;
    logic [QW-1:0] fq_data, qb_data;

    // Front stage: decode and bucket index.
    chm_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_key    (s_tdata[chm_pkg::KEY_W-1:0]),
        .s_val    (s_tdata[chm_pkg::KEY_W +: chm_pkg::VAL_W]),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    // Decoupling queue between the two stages.
    chm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // Back stage: bucket read, compare, write-back and result register.
    chm_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_tuser),
        .m_value  (m_tdata)
    );

endmodule

// ===== rtl/chm_ram.sv =====
// ----------------------------------------------------------------------------
// chm_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chm_front.sv =====
// ----------------------------------------------------------------------------
// chm_front: input stage of the hash map
// Takes a word, decodes the operation and reduces the key to a bucket index.
// ----------------------------------------------------------------------------
module chm_front #(
    parameter int BUCKETS = chm_pkg::DEF_BUCKETS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chm_pkg::KIND_W-1:0]    s_kind,
    input  logic [chm_pkg::KEY_W-1:0]     s_key,
    input  logic [chm_pkg::VAL_W-1:0]     s_val,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [chm_pkg::OP_W + chm_pkg::KEY_W + (BUCKETS > 1 ? $clog2(BUCKETS) : 1)
                  + chm_pkg::VAL_W - 1:0] q_data
);

    localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [IW:0] BK = (IW + 1)'(BUCKETS);
    localparam logic [chm_pkg::STEP_W-1:0] LAST_STEP =
        chm_pkg::STEP_W'(chm_pkg::REM_STEPS - 1);

    logic                           busy_reg, busy_next;
    logic [chm_pkg::STEP_W-1:0]     step_reg, step_next;
    chm_pkg::op_t                   op_reg, op_next, op_dec;
    logic [chm_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [chm_pkg::VAL_W-1:0]      val_reg, val_next;
    logic [IW:0]                    rem_reg, rem_next, rem_step;
    logic [chm_pkg::REM_BITS-1:0]   chunk;
    logic                           last, push, accept;

    always_comb begin
        unique case (s_kind)
            chm_pkg::KIND_ADD:    op_dec = chm_pkg::OP_ADD;
            chm_pkg::KIND_DELETE: op_dec = chm_pkg::OP_DEL;
            default:              op_dec = chm_pkg::OP_FIND;
        endcase
    end

    // Restoring remainder, most significant key bits first.
    assign chunk = key_reg[(chm_pkg::REM_STEPS - 1 - int'(step_reg)) * chm_pkg::REM_BITS
                           +: chm_pkg::REM_BITS];

    always_comb begin
        rem_step = rem_reg;
        for (int i = chm_pkg::REM_BITS - 1; i >= 0; i--) begin
            rem_step = {rem_step[IW-1:0], chunk[i]};
            if (rem_step >= BK) begin
                rem_step = rem_step - BK;
            end
        end
    end

    assign last     = (step_reg == LAST_STEP);
    assign q_valid  = busy_reg && last;
    assign push     = q_valid && q_ready;
    assign s_tready = !busy_reg || push;
    assign accept   = s_tvalid && s_tready;
    assign q_data   = {op_reg, key_reg, rem_step[IW-1:0], val_reg};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        op_next   = op_reg;
        key_next  = key_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        if (busy_reg && !last) begin
            rem_next  = rem_step;
            step_next = step_reg + 1'b1;
        end
        if (push) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            op_next   = op_dec;
            key_next  = s_key;
            val_next  = s_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== rtl/chm_queue.sv =====
// ----------------------------------------------------------------------------
// chm_queue: short FIFO between front and back
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module chm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (chm_pkg::QUEUE_DEPTH > 1) ? $clog2(chm_pkg::QUEUE_DEPTH) : 1;
    localparam logic [PW:0] FULL_CNT = (PW + 1)'(chm_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(chm_pkg::QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [chm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             wr, rd;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd && !wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/chm_back.sv =====
// ----------------------------------------------------------------------------
// chm_back: bucket engine of the hash map
// Reads a bucket, compares its ways, writes the bucket back and gives the result.
// ----------------------------------------------------------------------------
module chm_back #(
    parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
    parameter int WAYS    = chm_pkg::DEF_WAYS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [chm_pkg::OP_W + chm_pkg::KEY_W + (BUCKETS > 1 ? $clog2(BUCKETS) : 1)
                  + chm_pkg::VAL_W - 1:0]  q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [chm_pkg::STATUS_W-1:0]   m_status,
    output logic [chm_pkg::VAL_W-1:0]      m_value
);

    localparam int IW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEY_W  = chm_pkg::KEY_W;
    localparam int VAL_W  = chm_pkg::VAL_W;
    localparam int SLOT_W = KEY_W + 1;
    localparam int KROW_W = WAYS * SLOT_W;
    localparam int VROW_W = WAYS * VAL_W;
    localparam int QW     = chm_pkg::OP_W + KEY_W + IW + VAL_W;
    localparam logic [IW-1:0] LAST_BKT = IW'(BUCKETS - 1);

    chm_pkg::back_state_t state_reg, state_next;
    chm_pkg::op_t         op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [IW-1:0]        bkt_reg, bkt_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic                 hit_reg, hit_next, free_reg, free_next;
    logic [WW-1:0]        hit_way_reg, hit_way_next, free_way_reg, free_way_next;
    logic                 out_valid_reg, out_valid_next;
    chm_pkg::status_t     out_status_reg, out_status_next;
    logic [VAL_W-1:0]     out_value_reg, out_value_next;

    // Queue entry fields, op in the top bits and value in the bottom.
    chm_pkg::op_t         q_op;
    logic [KEY_W-1:0]     q_key;
    logic [IW-1:0]        q_bkt;
    logic [VAL_W-1:0]     q_val;

    logic                 k_we, v_we, rd_en;
    logic [IW-1:0]        k_waddr, raddr;
    logic [KROW_W-1:0]    k_wdata, k_rdata;
    logic [VROW_W-1:0]    v_wdata, v_rdata;

    logic [WAYS-1:0]      match, empty;
    logic                 any_hit, any_free;
    logic [WW-1:0]        hit_w, free_w;
    logic                 out_free;

    assign q_op  = chm_pkg::op_t'(q_data[QW-1 -: chm_pkg::OP_W]);
    assign q_key = q_data[VAL_W + IW +: KEY_W];
    assign q_bkt = q_data[VAL_W +: IW];
    assign q_val = q_data[VAL_W-1:0];

    chm_ram #(
        .WIDTH (KROW_W),
        .DEPTH (BUCKETS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (k_rdata)
    );

    chm_ram #(
        .WIDTH (VROW_W),
        .DEPTH (BUCKETS)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (bkt_reg),
        .wdata (v_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (v_rdata)
    );

    // Way compare; the lowest matching and the lowest free way win.
    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_w    = '0;
        free_w   = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = (k_rdata[w*SLOT_W +: SLOT_W] == {1'b1, key_reg});
            empty[w] = !k_rdata[w*SLOT_W + KEY_W];
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                any_hit = 1'b1;
                hit_w   = WW'(w);
            end
            if (empty[w]) begin
                any_free = 1'b1;
                free_w   = WW'(w);
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        bkt_next        = bkt_reg;
        val_next        = val_reg;
        clr_next        = clr_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        hit_way_next    = hit_way_reg;
        free_way_next   = free_way_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        q_ready         = 1'b0;
        rd_en           = 1'b0;
        raddr           = q_bkt;
        k_we            = 1'b0;
        k_waddr         = bkt_reg;
        k_wdata         = k_rdata;
        v_we            = 1'b0;
        v_wdata         = v_rdata;

        unique case (state_reg)
            chm_pkg::BK_CLEAR: begin
                k_we     = 1'b1;
                k_waddr  = clr_reg;
                k_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_BKT) begin
                    state_next = chm_pkg::BK_FETCH;
                end
            end
            chm_pkg::BK_FETCH: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    rd_en      = 1'b1;
                    op_next    = q_op;
                    key_next   = q_key;
                    bkt_next   = q_bkt;
                    val_next   = q_val;
                    state_next = chm_pkg::BK_LOOK;
                end
            end
            chm_pkg::BK_LOOK: begin
                hit_next      = any_hit;
                hit_way_next  = hit_w;
                free_next     = any_free;
                free_way_next = free_w;
                state_next    = chm_pkg::BK_EXEC;
            end
            chm_pkg::BK_EXEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    state_next     = chm_pkg::BK_FETCH;
                    unique case (op_reg)
                        chm_pkg::OP_ADD: begin
                            if (hit_reg) begin
                                v_we = 1'b1;
                                v_wdata[hit_way_reg*VAL_W +: VAL_W] = val_reg;
                                out_status_next = chm_pkg::ST_UPDATED;
                            end else if (free_reg) begin
                                k_we = 1'b1;
                                k_wdata[free_way_reg*SLOT_W +: SLOT_W] = {1'b1, key_reg};
                                v_we = 1'b1;
                                v_wdata[free_way_reg*VAL_W +: VAL_W] = val_reg;
                                out_status_next = chm_pkg::ST_ADDED;
                            end else begin
                                out_status_next = chm_pkg::ST_FULL;
                            end
                        end
                        chm_pkg::OP_DEL: begin
                            if (hit_reg) begin
                                k_we = 1'b1;
                                k_wdata[hit_way_reg*SLOT_W +: SLOT_W] = '0;
                                out_status_next = chm_pkg::ST_DELETED;
                            end else begin
                                out_status_next = chm_pkg::ST_DEL_MISSING;
                            end
                        end
                        default: begin
                            if (hit_reg) begin
                                out_value_next  = v_rdata[hit_way_reg*VAL_W +: VAL_W];
                                out_status_next = chm_pkg::ST_FOUND;
                            end else begin
                                out_status_next = chm_pkg::ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = chm_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= chm_pkg::BK_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        bkt_reg        <= bkt_next;
        val_reg        <= val_next;
        hit_reg        <= hit_next;
        free_reg       <= free_next;
        hit_way_reg    <= hit_way_next;
        free_way_reg   <= free_way_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_value  = out_value_reg;

endmodule
